>>> rtl/core/rti_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rti_pkg: shared constants and types for the ray/triangle intersection core
// Register indexes, reset values, output formats and control word types.
// ============================================================================
package rti_pkg;

	localparam int COORD_BITS_DEF = 20;   // default coordinate width
	localparam int QUEUE_DEPTH    = 8;    // front-to-back queue entries
	localparam int QUO_BITS       = 32;   // quotient bits per divider
	localparam int T_FRAC         = 16;   // fraction bits of t, u and v
	localparam int DET_EPS_W      = 63;
	localparam int DIST_EPS_W     = 32;
	localparam int BARY_W         = 17;

	localparam logic [DET_EPS_W-1:0]  DET_EPS_RST  = 63'd1074;
	localparam logic [DIST_EPS_W-1:0] DIST_EPS_RST = 32'd0;

	typedef enum logic {
		CFG_DET_EPS  = 1'b0,
		CFG_DIST_EPS = 1'b1
	} cfg_idx_t;

	// Classification of one test, carried with its numerators
	typedef struct packed {
		logic miss;   // rejected by determinant, barycentric or sign test
		logic sat;    // distance quotient overflows 32 bits
	} cls_t;

endpackage

>>> rtl/core/rti_front.sv
`timescale 1ns / 1ps
// ============================================================================
// rti_front: edge, cross and dot product pipeline with test classification
// Seven free-running stages; input admission is credit based on queue room.
// ============================================================================
module rti_front #(
	parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
	parameter int QDEPTH     = rti_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [3*COORD_BITS-1:0]        vertex_a,
	input  logic [3*COORD_BITS-1:0]        vertex_b,
	input  logic [3*COORD_BITS-1:0]        vertex_c,
	input  logic [3*COORD_BITS-1:0]        ray_origin,
	input  logic [3*COORD_BITS-1:0]        ray_direction,
	input  logic [rti_pkg::DET_EPS_W-1:0]  det_eps,
	input  logic                           pop,
	output logic                           push,
	output rti_pkg::cls_t                  cls,
	output logic [3*COORD_BITS+5:0]        det,
	output logic [3*COORD_BITS+5:0]        nu,
	output logic [3*COORD_BITS+5:0]        nv,
	output logic [3*COORD_BITS+5:0]        nt
);

	localparam int CW   = COORD_BITS;
	localparam int EW   = CW + 1;
	localparam int PW   = 2 * CW + 2;
	localparam int HW   = 2 * CW + 3;
	localparam int DPW  = 3 * CW + 4;
	localparam int DW   = 3 * CW + 6;
	localparam int XW   = DW + rti_pkg::T_FRAC;
	localparam int EPSW = (DW > rti_pkg::DET_EPS_W) ? DW : rti_pkg::DET_EPS_W;
	localparam int CNTW = $clog2(QDEPTH + 1);

	logic signed [CW-1:0] va [3], vb [3], vc [3], vo [3], vd [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			va[i] = vertex_a[i*CW +: CW];
			vb[i] = vertex_b[i*CW +: CW];
			vc[i] = vertex_c[i*CW +: CW];
			vo[i] = ray_origin[i*CW +: CW];
			vd[i] = ray_direction[i*CW +: CW];
		end
	end

	logic accept;
	logic [CNTW-1:0] cnt_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// A word leaving the queue this cycle frees its credit at once
	assign in_ready = (cnt_q < CNTW'(QDEPTH)) || pop;
	assign accept   = in_valid && in_ready;

	// Credit: items inside the front stages plus items held in the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNTW'(accept) - CNTW'(pop);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <=
				{accept, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6};
		end
	end

	// Stage 1: edges and origin offset
	logic signed [EW-1:0] e1_s1 [3], e2_s1 [3], so_s1 [3];
	logic signed [CW-1:0] dir_s1 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			e1_s1[i]  <= EW'(vb[i]) - EW'(va[i]);
			e2_s1[i]  <= EW'(vc[i]) - EW'(va[i]);
			so_s1[i]  <= EW'(vo[i]) - EW'(va[i]);
			dir_s1[i] <= vd[i];
		end
	end

	// Stage 2: cross product terms of h = dir x e2 and q = s x e1
	logic signed [PW-1:0] ph_s2 [6], pq_s2 [6];
	logic signed [EW-1:0] e1_s2 [3], e2_s2 [3], so_s2 [3];
	logic signed [CW-1:0] dir_s2 [3];

	always_ff @(posedge clk) begin
		ph_s2[0] <= dir_s1[1] * e2_s1[2];
		ph_s2[1] <= dir_s1[2] * e2_s1[1];
		ph_s2[2] <= dir_s1[2] * e2_s1[0];
		ph_s2[3] <= dir_s1[0] * e2_s1[2];
		ph_s2[4] <= dir_s1[0] * e2_s1[1];
		ph_s2[5] <= dir_s1[1] * e2_s1[0];
		pq_s2[0] <= so_s1[1] * e1_s1[2];
		pq_s2[1] <= so_s1[2] * e1_s1[1];
		pq_s2[2] <= so_s1[2] * e1_s1[0];
		pq_s2[3] <= so_s1[0] * e1_s1[2];
		pq_s2[4] <= so_s1[0] * e1_s1[1];
		pq_s2[5] <= so_s1[1] * e1_s1[0];
		e1_s2  <= e1_s1;
		e2_s2  <= e2_s1;
		so_s2  <= so_s1;
		dir_s2 <= dir_s1;
	end

	// Stage 3: finish the cross products
	logic signed [HW-1:0] h_s3 [3], q_s3 [3];
	logic signed [EW-1:0] e1_s3 [3], e2_s3 [3], so_s3 [3];
	logic signed [CW-1:0] dir_s3 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			h_s3[i] <= HW'(ph_s2[2*i]) - HW'(ph_s2[2*i+1]);
			q_s3[i] <= HW'(pq_s2[2*i]) - HW'(pq_s2[2*i+1]);
		end
		e1_s3  <= e1_s2;
		e2_s3  <= e2_s2;
		so_s3  <= so_s2;
		dir_s3 <= dir_s2;
	end

	// Stage 4: dot product terms
	logic signed [DPW-1:0] pd_s4 [3], pu_s4 [3], pv_s4 [3], pt_s4 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pd_s4[i] <= e1_s3[i] * h_s3[i];
			pu_s4[i] <= so_s3[i] * h_s3[i];
			pv_s4[i] <= dir_s3[i] * q_s3[i];
			pt_s4[i] <= e2_s3[i] * q_s3[i];
		end
	end

	// Stage 5: determinant and the three numerators
	logic signed [DW-1:0] det_s5, nu_s5, nv_s5, nt_s5;

	always_ff @(posedge clk) begin
		det_s5 <= DW'(pd_s4[0]) + DW'(pd_s4[1]) + DW'(pd_s4[2]);
		nu_s5  <= DW'(pu_s4[0]) + DW'(pu_s4[1]) + DW'(pu_s4[2]);
		nv_s5  <= DW'(pv_s4[0]) + DW'(pv_s4[1]) + DW'(pv_s4[2]);
		nt_s5  <= DW'(pt_s4[0]) + DW'(pt_s4[1]) + DW'(pt_s4[2]);
	end

	// Stage 6: flip signs so the determinant is not negative
	logic signed [DW-1:0] det_s6, nu_s6, nv_s6, nt_s6;

	always_ff @(posedge clk) begin
		if (det_s5 < 0) begin
			det_s6 <= -det_s5;
			nu_s6  <= -nu_s5;
			nv_s6  <= -nv_s5;
			nt_s6  <= -nt_s5;
		end else begin
			det_s6 <= det_s5;
			nu_s6  <= nu_s5;
			nv_s6  <= nv_s5;
			nt_s6  <= nt_s5;
		end
	end

	// Stage 7: classify on exact values, flag distance overflow
	logic miss_c, sat_c;
	logic [DW:0] uv_sum;
	rti_pkg::cls_t cls_s7;
	logic [DW-1:0] det_s7, nu_s7, nv_s7, nt_s7;

	always_comb begin
		uv_sum = (DW+1)'(nu_s6) + (DW+1)'(nv_s6);
		miss_c = (det_s6 == '0)
			|| (EPSW'($unsigned(det_s6)) < EPSW'(det_eps))
			|| (nu_s6 < 0) || (nu_s6 > det_s6)
			|| (nv_s6 < 0) || ($signed(uv_sum) > (DW+1)'(det_s6))
			|| (nt_s6 < 0);
		sat_c  = XW'($unsigned(nt_s6)) >=
			{$unsigned(det_s6), {rti_pkg::T_FRAC{1'b0}}};
	end

	always_ff @(posedge clk) begin
		cls_s7.miss <= miss_c;
		cls_s7.sat  <= sat_c;
		det_s7      <= det_s6;
		nu_s7       <= nu_s6;
		nv_s7       <= nv_s6;
		// Zero keeps the divider's first remainder below any nonzero divisor
		nt_s7       <= (miss_c || sat_c) ? '0 : nt_s6;
	end

	assign push = v_s7;
	assign cls  = cls_s7;
	assign det  = det_s7;
	assign nu   = nu_s7;
	assign nv   = nv_s7;
	assign nt   = nt_s7;

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(QDEPTH))
		else $error("front credit count above queue depth");

	a_pop_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != '0))
		else $error("queue pop with no item in flight");

endmodule

>>> rtl/core/rti_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// rti_queue: short circular queue between classifier and divider
// Head word is shown combinationally; room is guaranteed by front credit.
// ============================================================================
module rti_queue #(
	parameter int W     = 8,
	parameter int DEPTH = rti_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

endmodule

>>> rtl/core/rti_back.sv
`timescale 1ns / 1ps
// ============================================================================
// rti_back: pipelined restoring dividers for t, u and v plus result register
// One subtract stage per quotient bit; all stages stall together on output.
// ============================================================================
module rti_back #(
	parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  rti_pkg::cls_t                   cls,
	input  logic [3*COORD_BITS+5:0]         det,
	input  logic [3*COORD_BITS+5:0]         nu,
	input  logic [3*COORD_BITS+5:0]         nv,
	input  logic [3*COORD_BITS+5:0]         nt,
	input  logic [rti_pkg::DIST_EPS_W-1:0]  dist_eps,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic [31:0]                     distance,
	output logic [rti_pkg::BARY_W-1:0]      bary_u,
	output logic [rti_pkg::BARY_W-1:0]      bary_v
);

	localparam int DW = 3 * COORD_BITS + 6;
	localparam int QB = rti_pkg::QUO_BITS;
	localparam int TF = rti_pkg::T_FRAC;

	// Per stage: remainder and a shift word that feeds numerator bits out
	// of its top and takes quotient bits in at its bottom (t, u, v lanes)
	logic [DW-1:0]       rem_s [QB+1][3];
	logic [QB-1:0]       sh_s  [QB+1][3];
	logic [DW-1:0]       d_s   [QB+1];
	rti_pkg::cls_t       cls_s [QB+1];
	logic [QB:0]         vld_s;

	logic out_valid_q, hit_q;
	logic [31:0] distance_q;
	logic [rti_pkg::BARY_W-1:0] bary_u_q, bary_v_q;
	logic en;
	logic [DW-1:0] num [3];

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;
	assign num[0]   = nt;
	assign num[1]   = nu;
	assign num[2]   = nv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s       <= {vld_s[QB-1:0], in_valid};
			out_valid_q <= vld_s[QB];
		end
	end

	// Load: remainder starts at numerator >> 16, which is below the divisor for any test that is not a miss
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				rem_s[0][j] <= num[j] >> TF;
				sh_s[0][j]  <= {num[j][TF-1:0], {(QB-TF){1'b0}}};
			end
			d_s[0]   <= det;
			cls_s[0] <= cls;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [DW-1:0] r2 [3];
		logic          ge [3];

		always_comb begin
			for (int j = 0; j < 3; j++) begin
				r2[j] = {rem_s[k-1][j][DW-2:0], sh_s[k-1][j][QB-1]};
				ge[j] = (r2[j] >= d_s[k-1]);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					rem_s[k][j] <= ge[j] ? r2[j] - d_s[k-1] : r2[j];
					sh_s[k][j]  <= {sh_s[k-1][j][QB-2:0], ge[j]};
				end
				d_s[k]   <= d_s[k-1];
				cls_s[k] <= cls_s[k-1];
			end
		end
	end

	logic [31:0] t_full;
	logic        hit_c;

	always_comb begin
		t_full = cls_s[QB].sat ? '1 : sh_s[QB][0];
		hit_c  = !cls_s[QB].miss && (t_full > dist_eps);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q      <= hit_c;
			distance_q <= hit_c ? t_full : '0;
			bary_u_q   <= hit_c ? sh_s[QB][1][rti_pkg::BARY_W-1:0] : '0;
			bary_v_q   <= hit_c ? sh_s[QB][2][rti_pkg::BARY_W-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign distance  = distance_q;
	assign bary_u    = bary_u_q;
	assign bary_v    = bary_v_q;

	a_hit_beyond_eps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> (distance > dist_eps))
		else $error("hit reported at or below minimum distance");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (distance == '0 && bary_u == '0 && bary_v == '0))
		else $error("miss carries nonzero fields");

	a_bary_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bary_u <= 17'd65536 && bary_v <= 17'd65536))
		else $error("barycentric value above one");

endmodule

>>> rtl/core/ray_triangle_intersect.sv
`timescale 1ns / 1ps
// ============================================================================
// ray_triangle_intersect: streaming exact ray/triangle hit test
// Fixed-point Moller-Trumbore test with distance and barycentric output.
// ============================================================================
// One test word per clock is accepted and one result word per clock is
// delivered when both sides keep up. Each test passes through seven
// classifier stages, the queue, a load stage, 32 divider stages (one quotient
// bit per stage, for t, u and v in parallel) and the result register. The
// queue holds 8 words, and input ready drops only when the classifier and
// queue together hold 8 words that the divider pipeline has not yet taken,
// so the front keeps flowing while the output stalls for a short while.
// det_epsilon is on the determinant scale (three times the coordinate
// fraction bits); write registers only while idle.
// ============================================================================
module ray_triangle_intersect #(
	parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_write,
	input  logic                            cfg_index,
	input  logic [rti_pkg::DET_EPS_W-1:0]   cfg_data,
	// test words
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [3*COORD_BITS-1:0]         vertex_a,
	input  logic [3*COORD_BITS-1:0]         vertex_b,
	input  logic [3*COORD_BITS-1:0]         vertex_c,
	input  logic [3*COORD_BITS-1:0]         ray_origin,
	input  logic [3*COORD_BITS-1:0]         ray_direction,
	// result words
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic [31:0]                     distance,
	output logic [rti_pkg::BARY_W-1:0]      bary_u,
	output logic [rti_pkg::BARY_W-1:0]      bary_v
);

	localparam int DW = 3 * COORD_BITS + 6;
	localparam int QW = $bits(rti_pkg::cls_t) + 4 * DW;

	logic [rti_pkg::DET_EPS_W-1:0]  det_eps_q;
	logic [rti_pkg::DIST_EPS_W-1:0] dist_eps_q;

	// Hold the two thresholds; take writes whenever the enable is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_eps_q  <= rti_pkg::DET_EPS_RST;
			dist_eps_q <= rti_pkg::DIST_EPS_RST;
		end else if (cfg_write) begin
			unique case (rti_pkg::cfg_idx_t'(cfg_index))
				rti_pkg::CFG_DET_EPS:  det_eps_q  <= cfg_data;
				rti_pkg::CFG_DIST_EPS: dist_eps_q <= cfg_data[rti_pkg::DIST_EPS_W-1:0];
			endcase
		end
	end

	// Front: edges, products, classification
	logic          push, pop, q_not_empty, back_ready;
	rti_pkg::cls_t f_cls, h_cls;
	logic [DW-1:0] f_det, f_nu, f_nv, f_nt;
	logic [DW-1:0] h_det, h_nu, h_nv, h_nt;
	logic [QW-1:0] q_head;

	rti_front #(
		.COORD_BITS (COORD_BITS),
		.QDEPTH     (rti_pkg::QUEUE_DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.vertex_a      (vertex_a),
		.vertex_b      (vertex_b),
		.vertex_c      (vertex_c),
		.ray_origin    (ray_origin),
		.ray_direction (ray_direction),
		.det_eps       (det_eps_q),
		.pop           (pop),
		.push          (push),
		.cls           (f_cls),
		.det           (f_det),
		.nu            (f_nu),
		.nv            (f_nv),
		.nt            (f_nt)
	);

	// Queue: decouple classifier from divider stalls
	rti_queue #(
		.W     (QW),
		.DEPTH (rti_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({f_cls, f_det, f_nu, f_nv, f_nt}),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	assign {h_cls, h_det, h_nu, h_nv, h_nt} = q_head;
	// Advance the head whenever the divider pipeline takes a word
	assign pop = q_not_empty && back_ready;

	// Back: dividers, distance threshold, result register
	rti_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_not_empty),
		.in_ready  (back_ready),
		.cls       (h_cls),
		.det       (h_det),
		.nu        (h_nu),
		.nv        (h_nv),
		.nt        (h_nt),
		.dist_eps  (dist_eps_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit       (hit),
		.distance  (distance),
		.bary_u    (bary_u),
		.bary_v    (bary_v)
	);

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: ray/triangle intersection core
// Streams ray/triangle tests through the core under random idling, predicts
// each result with an exact wide-integer model and checks every result word.
// ============================================================================
module testbench;

	localparam int CB     = rti_pkg::COORD_BITS_DEF;
	localparam int MAXC   = (1 << (CB - 1)) - 1;
	localparam int MINC   = -(1 << (CB - 1));
	localparam int SETTLE = 60;   // extra wait after the last result, in clock cycles

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic [3*CB-1:0] va, vb, vc, org, dir;
	} ray_test_t;

	typedef struct {
		logic                       hit;
		logic [31:0]                dist_val;
		logic [rti_pkg::BARY_W-1:0] u, v;
	} hit_word_t;

	logic clk, arst_n;
	logic cfg_write, cfg_index;
	logic [rti_pkg::DET_EPS_W-1:0] cfg_data;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [3*CB-1:0] vertex_a, vertex_b, vertex_c, ray_origin, ray_direction;
	logic hit;
	logic [31:0] distance;
	logic [rti_pkg::BARY_W-1:0] bary_u, bary_v;

	// shadow copy of the core's thresholds
	logic [rti_pkg::DET_EPS_W-1:0]  det_eps_sh;
	logic [rti_pkg::DIST_EPS_W-1:0] dist_eps_sh;

	ray_test_t pending_tests[$];
	hit_word_t expected_hits[$];
	ray_test_t drv_test;
	int mismatch_count;
	bit no_idle;
	int stall_req, stall_done, hold_cycles;

	ray_triangle_intersect dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.vertex_a(vertex_a), .vertex_b(vertex_b), .vertex_c(vertex_c),
		.ray_origin(ray_origin), .ray_direction(ray_direction),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .distance(distance), .bary_u(bary_u), .bary_v(bary_v)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor
	function automatic longint coord(logic [3*CB-1:0] w, int i);
		logic signed [CB-1:0] f;
		f = w[i*CB +: CB];
		return longint'(f);
	endfunction

	function automatic wide_t dot3(longint a[3], longint b[3]);
		wide_t r;
		r = 0;
		for (int i = 0; i < 3; i++) r += wide_t'(a[i]) * wide_t'(b[i]);
		return r;
	endfunction

	// Exact Moller-Trumbore test; every quantity fits a 128-bit signed value.
	function automatic hit_word_t intersect_ray(ray_test_t x);
		longint e1[3], e2[3], s[3], d[3], h[3], q[3];
		wide_t det, nu, nv, nt, tq;
		hit_word_t r;
		r = '{hit: 1'b0, dist_val: '0, u: '0, v: '0};
		for (int i = 0; i < 3; i++) begin
			e1[i] = coord(x.vb, i) - coord(x.va, i);
			e2[i] = coord(x.vc, i) - coord(x.va, i);
			s[i]  = coord(x.org, i) - coord(x.va, i);
			d[i]  = coord(x.dir, i);
		end
		h[0] = d[1] * e2[2] - d[2] * e2[1];
		h[1] = d[2] * e2[0] - d[0] * e2[2];
		h[2] = d[0] * e2[1] - d[1] * e2[0];
		q[0] = s[1] * e1[2] - s[2] * e1[1];
		q[1] = s[2] * e1[0] - s[0] * e1[2];
		q[2] = s[0] * e1[1] - s[1] * e1[0];
		det = dot3(e1, h);
		nu  = dot3(s, h);
		nv  = dot3(d, q);
		nt  = dot3(e2, q);
		// fold the sign of det into the numerators
		if (det < 0) begin
			det = -det; nu = -nu; nv = -nv; nt = -nt;
		end
		if (det == 0 || det < wide_t'(det_eps_sh)) return r;
		if (nu < 0 || nu > det) return r;
		if (nv < 0 || nu + nv > det) return r;
		if (nt < 0) return r;
		tq = (nt <<< rti_pkg::T_FRAC) / det;
		r.dist_val = (tq > wide_t'(64'hFFFF_FFFF)) ? 32'hFFFF_FFFF : tq[31:0];
		if (r.dist_val <= dist_eps_sh) begin
			r.dist_val = '0;
			return r;
		end
		tq  = (nu <<< rti_pkg::T_FRAC) / det;
		r.u = tq[rti_pkg::BARY_W-1:0];
		tq  = (nv <<< rti_pkg::T_FRAC) / det;
		r.v = tq[rti_pkg::BARY_W-1:0];
		r.hit = 1'b1;
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus
	function automatic logic [3*CB-1:0] pack3(int x, int y, int z);
		logic [31:0] ux, uy, uz;
		ux = x; uy = y; uz = z;
		return {uz[CB-1:0], uy[CB-1:0], ux[CB-1:0]};
	endfunction

	function automatic int rnd(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic [3*CB-1:0] rnd_word();
		return (3*CB)'({$urandom, $urandom});
	endfunction

	task automatic push_test(logic [3*CB-1:0] a, b, c, o, d);
		ray_test_t t;
		t = '{va: a, vb: b, vc: c, org: o, dir: d};
		pending_tests.push_back(t);
	endtask

	// Aim a ray from a random origin at the point a + (r1*e1 + r2*e2)/256,
	// scaled down by k so that t lands near k; flip it to point away if asked.
	task automatic push_aimed(int span, int r1, int r2, int k, bit away);
		int a[3], b[3], c[3], o[3], d[3], p;
		for (int i = 0; i < 3; i++) begin
			a[i] = rnd(span); b[i] = rnd(span); c[i] = rnd(span); o[i] = rnd(span);
			p = a[i] + ((b[i] - a[i]) * r1 + (c[i] - a[i]) * r2) / 256;
			d[i] = (p - o[i]) / k;
			if (away) d[i] = -d[i];
		end
		push_test(pack3(a[0], a[1], a[2]), pack3(b[0], b[1], b[2]),
			pack3(c[0], c[1], c[2]), pack3(o[0], o[1], o[2]), pack3(d[0], d[1], d[2]));
	endtask

	task automatic push_directed();
		// degenerate: everything zero, everything ones
		push_test('0, '0, '0, '0, '0);
		push_test('1, '1, '1, '1, '1);
		// widest triangle hit head-on by the longest ray
		push_test(pack3(MINC, MINC, 0), pack3(MAXC, MINC, 0), pack3(MINC, MAXC, 0),
			pack3(-100, -100, MAXC), pack3(0, 0, MINC));
		push_test(pack3(MINC, MINC, 0), pack3(MAXC, MINC, 0), pack3(MINC, MAXC, 0),
			pack3(-100, -100, MINC), pack3(0, 0, MAXC));
		// ray parallel to the triangle plane
		push_test(pack3(0, 0, 0), pack3(1024, 0, 0), pack3(0, 1024, 0),
			pack3(100, 100, 500), pack3(1024, 512, 0));
		// tiny triangle: determinant far below the default threshold
		push_test(pack3(0, 0, 0), pack3(1, 0, 0), pack3(0, 1, 0),
			pack3(0, 0, 1), pack3(0, 0, -1));
		// through the corners (u = 0 / u = 1 / v = 1), an edge and the center
		push_aimed(2048, 0, 0, 1, 1'b0);
		push_aimed(2048, 256, 0, 1, 1'b0);
		push_aimed(2048, 0, 256, 1, 1'b0);
		push_aimed(2048, 128, 128, 2, 1'b0);
		push_aimed(4096, 85, 85, 3, 1'b0);
		// outside the triangle, and behind the origin
		push_aimed(2048, 200, 200, 1, 1'b0);
		push_aimed(2048, 85, 85, 1, 1'b1);
		// far away: distance saturates
		push_test(pack3(0, 0, 0), pack3(1024, 0, 0), pack3(0, 1024, 0),
			pack3(100, 100, MAXC), pack3(0, 0, -1));
	endtask

	task automatic push_random(int n);
		int span, r1;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: span = 64;
				1: span = 2048;
				2: span = 1 << 15;
				default: span = 1 << 17;
			endcase
			if ($urandom_range(99) < 75) begin
				r1 = $urandom_range(0, 256);
				push_aimed(span, r1, $urandom_range(0, 256 - r1), $urandom_range(1, 8),
					$urandom_range(9) == 0);
			end else if ($urandom_range(1)) begin
				push_test(rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word());
			end else begin
				push_test(pack3(rnd(span), rnd(span), rnd(span)),
					pack3(rnd(span), rnd(span), rnd(span)),
					pack3(rnd(span), rnd(span), rnd(span)),
					pack3(rnd(span), rnd(span), rnd(span)),
					pack3(rnd(span), rnd(span), rnd(span)));
			end
		end
	endtask

	// Write one threshold; only called with the core drained.
	task automatic write_reg(rti_pkg::cfg_idx_t idx, logic [rti_pkg::DET_EPS_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == rti_pkg::CFG_DET_EPS) det_eps_sh = value;
		else dist_eps_sh = value[rti_pkg::DIST_EPS_W-1:0];
	endtask

	// Hold until every test is sent and answered, then let the pipe settle.
	task automatic drain();
		while (pending_tests.size() > 0 || in_valid || expected_hits.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- sequence
	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = rti_pkg::CFG_DET_EPS;
		cfg_data = '0;
		det_eps_sh = rti_pkg::DET_EPS_RST;
		dist_eps_sh = rti_pkg::DIST_EPS_RST;
		mismatch_count = 0;
		no_idle = 1'b0;
		stall_req = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset thresholds
		push_directed();
		push_random(250);
		drain();

		// no thresholds at all; hold the result side off to fill the queue
		write_reg(rti_pkg::CFG_DET_EPS, '0);
		write_reg(rti_pkg::CFG_DIST_EPS, '0);
		push_directed();
		push_random(250);
		stall_req++;
		drain();

		// largest determinant threshold: every test misses
		write_reg(rti_pkg::CFG_DET_EPS, {rti_pkg::DET_EPS_W{1'b1}});
		write_reg(rti_pkg::CFG_DIST_EPS, rti_pkg::DET_EPS_W'($urandom));
		push_directed();
		push_random(150);
		drain();

		// largest distance threshold, written with junk above bit 31
		write_reg(rti_pkg::CFG_DET_EPS,
			rti_pkg::DET_EPS_W'({$urandom_range(255), $urandom}));
		write_reg(rti_pkg::CFG_DIST_EPS, {31'h5A5A_1234, 32'hFFFF_FFFF});
		push_directed();
		push_random(150);
		drain();

		// beyond t = 1 only, full rate on both sides
		write_reg(rti_pkg::CFG_DET_EPS, 63'd1);
		write_reg(rti_pkg::CFG_DIST_EPS, 63'd65536);
		no_idle = 1'b1;
		push_directed();
		push_random(300);
		drain();
		no_idle = 1'b0;

		// random thresholds
		write_reg(rti_pkg::CFG_DET_EPS, rti_pkg::DET_EPS_W'($urandom_range(0, 1 << 20)));
		write_reg(rti_pkg::CFG_DIST_EPS, rti_pkg::DET_EPS_W'($urandom_range(0, 200000)));
		push_directed();
		push_random(300);
		stall_req++;
		drain();

		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end

	// ---------------------------------------------------------------- driver
	// Record the word taken at this edge, then offer the next one unless idling.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			vertex_a <= '0;
			vertex_b <= '0;
			vertex_c <= '0;
			ray_origin <= '0;
			ray_direction <= '0;
		end else begin
			if (in_valid && in_ready) expected_hits.push_back(intersect_ray(drv_test));
			if (!in_valid || in_ready) begin
				if (pending_tests.size() > 0 && (no_idle || $urandom_range(99) >= 9)) begin
					drv_test = pending_tests.pop_front();
					in_valid <= 1'b1;
					vertex_a <= drv_test.va;
					vertex_b <= drv_test.vb;
					vertex_c <= drv_test.vc;
					ray_origin <= drv_test.org;
					ray_direction <= drv_test.dir;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	task automatic flag_mismatch(string what);
		mismatch_count++;
		$display("%0t: mismatch: %s", $realtime, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_done = 0;
			hold_cycles = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_hits.size() == 0) begin
					flag_mismatch("result word with no test outstanding");
				end else begin
					hit_word_t e;
					e = expected_hits.pop_front();
					if (hit !== e.hit)
						flag_mismatch($sformatf("hit %b, expected %b", hit, e.hit));
					if (distance !== e.dist_val)
						flag_mismatch($sformatf("distance %h, expected %h",
							distance, e.dist_val));
					if (bary_u !== e.u)
						flag_mismatch($sformatf("bary_u %h, expected %h", bary_u, e.u));
					if (bary_v !== e.v)
						flag_mismatch($sformatf("bary_v %h, expected %h", bary_v, e.v));
				end
			end
			// a requested long hold-off backs the core up into its input
			if (stall_req != stall_done) begin
				stall_done++;
				hold_cycles = 300;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_idle || $urandom_range(99) >= 9;
			end
		end
	end

endmodule

>>> files.f
rtl/core/rti_pkg.sv
rtl/core/rti_front.sv
rtl/core/rti_queue.sv
rtl/core/rti_back.sv
rtl/core/ray_triangle_intersect.sv
bench/testbench.sv
